>>> rtl/core/cau_pkg.sv
// ----------------------------------------------------------------------------
// cau_pkg
// Shared types and codes for the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

  // Operation selected by each input beat.
  typedef enum logic [1:0] {
    ACT_ADD = 2'd0,
    ACT_SUB = 2'd1,
    ACT_MUL = 2'd2,
    ACT_DIV = 2'd3
  } action_t;

endpackage

>>> rtl/core/cau_if.sv
// ----------------------------------------------------------------------------
// cau_in_if / cau_out_if
// Valid/ready channels for operand beats and result beats.
// ----------------------------------------------------------------------------
interface cau_in_if #(
  parameter int DATA_WIDTH = 16
);
  import cau_pkg::*;

  logic                         valid;
  logic                         ready;
  action_t                      action;
  logic signed [DATA_WIDTH-1:0] a_re;
  logic signed [DATA_WIDTH-1:0] a_im;
  logic signed [DATA_WIDTH-1:0] b_re;
  logic signed [DATA_WIDTH-1:0] b_im;

  modport source (output valid, action, a_re, a_im, b_re, b_im, input ready);
  modport sink   (input valid, action, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cau_out_if #(
  parameter int DATA_WIDTH = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] res_re;
  logic signed [DATA_WIDTH-1:0] res_im;
  logic                         saturated;
  logic                         div_by_zero;

  modport source (output valid, res_re, res_im, saturated, div_by_zero, input ready);
  modport sink   (input valid, res_re, res_im, saturated, div_by_zero, output ready);
endinterface

>>> rtl/core/cau_div_step.sv
// ----------------------------------------------------------------------------
// cau_div_step
// One restoring division step: tries to take the divisor, shifted to one
// quotient bit position, out of the partial remainder.
// ----------------------------------------------------------------------------
module cau_div_step #(
  parameter int NW = 41,
  parameter int DW = 32,
  parameter int XW = 50,
  parameter int SH = 0
) (
  input  logic [NW-1:0] rem,
  input  logic [DW-1:0] den,
  output logic [NW-1:0] rem_nxt,
  output logic          qbit
);

  logic [XW-1:0] dsh;
  logic [XW-1:0] rx;
  logic [XW-1:0] diff;

  // Compare and subtract in a width that holds the shifted divisor.
  always_comb begin
    dsh     = XW'(den) << SH;
    rx      = XW'(rem);
    diff    = rx - dsh;
    qbit    = (rx >= dsh);
    rem_nxt = qbit ? diff[NW-1:0] : rem;
  end

endmodule

>>> rtl/core/complex_arith_unit.sv
// ----------------------------------------------------------------------------
// complex_arith_unit
// Pipelined complex add, subtract, multiply and divide on signed fixed point.
// Every action passes through the same stages from input beat to result beat;
// the restoring divider spends one stage per quotient bit.
// Throughput: one beat per cycle; a full stage holds while the next one holds.
// Reset clears only the stage valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
module complex_arith_unit #(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 8
) (
  input  logic  clk,
  input  logic  rst_n,
  cau_in_if.sink    in_ch,
  cau_out_if.source out_ch
);
  import cau_pkg::*;

  localparam int W  = DATA_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int DW = 2 * W;
  localparam int PW = 2 * W + 1;
  localparam int NW = PW + F;
  localparam int XW = ((NW > 3 * W) ? NW : 3 * W) + 1;

  typedef struct packed {
    logic                 div;
    logic                 dz;
    logic                 neg_re;
    logic                 neg_im;
    logic                 ovf_re;
    logic                 ovf_im;
    logic signed [PW-1:0] val_re;
    logic signed [PW-1:0] val_im;
  } meta_t;

  // Clip a wide signed value to W bits; bit W of the result is the clip flag.
  function automatic logic [W:0] sat_fn(logic signed [PW-1:0] x);
    logic signed [PW-1:0] maxv;
    logic signed [PW-1:0] minv;
    logic [W:0]           r;
    maxv = {{(PW-W+1){1'b0}}, {(W-1){1'b1}}};
    minv = {{(PW-W+1){1'b1}}, {(W-1){1'b0}}};
    if (x > maxv) begin
      r = {1'b1, maxv[W-1:0]};
    end else if (x < minv) begin
      r = {1'b1, minv[W-1:0]};
    end else begin
      r = {1'b0, x[W-1:0]};
    end
    return r;
  endfunction

  // Stage enables: a stage takes a beat when it is empty or its beat moves on.
  logic          en1;
  logic          en2;
  logic          en_out;
  logic [W:0]    en_d;

  // Stage 1: products and plain sums.
  logic                 v1_r;
  action_t              act1_r;
  logic signed [DW-1:0] prr_r, pii_r, pri_r, pir_r;
  logic [DW-1:0]        pbb_r, pcc_r;
  logic signed [W:0]    sre1_r, sim1_r;

  logic signed [DW-1:0] prr_nxt, pii_nxt, pri_nxt, pir_nxt, pbb_nxt, pcc_nxt;
  logic signed [W:0]    sre1_nxt, sim1_nxt;

  always_comb begin
    prr_nxt = in_ch.a_re * in_ch.b_re;
    pii_nxt = in_ch.a_im * in_ch.b_im;
    pri_nxt = in_ch.a_re * in_ch.b_im;
    pir_nxt = in_ch.a_im * in_ch.b_re;
    pbb_nxt = in_ch.b_re * in_ch.b_re;
    pcc_nxt = in_ch.b_im * in_ch.b_im;
    if (in_ch.action == ACT_SUB) begin
      sre1_nxt = {in_ch.a_re[W-1], in_ch.a_re} - {in_ch.b_re[W-1], in_ch.b_re};
      sim1_nxt = {in_ch.a_im[W-1], in_ch.a_im} - {in_ch.b_im[W-1], in_ch.b_im};
    end else begin
      sre1_nxt = {in_ch.a_re[W-1], in_ch.a_re} + {in_ch.b_re[W-1], in_ch.b_re};
      sim1_nxt = {in_ch.a_im[W-1], in_ch.a_im} + {in_ch.b_im[W-1], in_ch.b_im};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en1) begin
      v1_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      act1_r <= in_ch.action;
      prr_r  <= prr_nxt;
      pii_r  <= pii_nxt;
      pri_r  <= pri_nxt;
      pir_r  <= pir_nxt;
      pbb_r  <= DW'(pbb_nxt);
      pcc_r  <= DW'(pcc_nxt);
      sre1_r <= sre1_nxt;
      sim1_r <= sim1_nxt;
    end
  end

  // Stage 2: combine products, form divide numerators and the divisor.
  logic                 v2_r;
  meta_t                meta2_r;
  logic [NW-1:0]        num_re2_r, num_im2_r;
  logic [DW-1:0]        den2_r;

  meta_t                meta2_nxt;
  logic [NW-1:0]        num_re2_nxt, num_im2_nxt;
  logic [DW-1:0]        den2_nxt;
  logic signed [PW-1:0] xre, xim, nr, ni;
  logic [PW-1:0]        mag_re, mag_im;

  always_comb begin
    xre      = {prr_r[DW-1], prr_r} - {pii_r[DW-1], pii_r};
    xim      = {pri_r[DW-1], pri_r} + {pir_r[DW-1], pir_r};
    nr       = {prr_r[DW-1], prr_r} + {pii_r[DW-1], pii_r};
    ni       = {pir_r[DW-1], pir_r} - {pri_r[DW-1], pri_r};
    den2_nxt = pbb_r + pcc_r;
    mag_re   = nr[PW-1] ? PW'(-nr) : PW'(nr);
    mag_im   = ni[PW-1] ? PW'(-ni) : PW'(ni);
    num_re2_nxt = NW'(mag_re) << F;
    num_im2_nxt = NW'(mag_im) << F;
    meta2_nxt        = '0;
    meta2_nxt.neg_re = nr[PW-1];
    meta2_nxt.neg_im = ni[PW-1];
    unique case (act1_r)
      ACT_ADD, ACT_SUB: begin
        meta2_nxt.val_re = {{(PW-W-1){sre1_r[W]}}, sre1_r};
        meta2_nxt.val_im = {{(PW-W-1){sim1_r[W]}}, sim1_r};
      end
      ACT_MUL: begin
        meta2_nxt.val_re = xre >>> F;
        meta2_nxt.val_im = xim >>> F;
      end
      ACT_DIV: begin
        meta2_nxt.div = 1'b1;
        meta2_nxt.dz  = (den2_nxt == '0);
      end
      default: begin
        meta2_nxt.val_re = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      meta2_r   <= meta2_nxt;
      num_re2_r <= num_re2_nxt;
      num_im2_r <= num_im2_nxt;
      den2_r    <= den2_nxt;
    end
  end

  // Divider pipeline: entry 0 holds the overflow test, entry k bit W-k.
  logic          vd_r   [0:W];
  meta_t         meta_r [0:W];
  logic [NW-1:0] rre_r  [0:W];
  logic [NW-1:0] rim_r  [0:W];
  logic [W-1:0]  qre_r  [0:W];
  logic [W-1:0]  qim_r  [0:W];
  logic [DW-1:0] den_r  [0:W];

  // Entry stage: a quotient of 2^W or more always saturates.
  meta_t         meta0_nxt;
  logic [XW-1:0] dtop;

  always_comb begin
    dtop             = XW'(den2_r) << W;
    meta0_nxt        = meta2_r;
    meta0_nxt.ovf_re = (XW'(num_re2_r) >= dtop);
    meta0_nxt.ovf_im = (XW'(num_im2_r) >= dtop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r[0] <= 1'b0;
    end else if (en_d[0]) begin
      vd_r[0] <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_d[0]) begin
      meta_r[0] <= meta0_nxt;
      rre_r[0]  <= num_re2_r;
      rim_r[0]  <= num_im2_r;
      qre_r[0]  <= '0;
      qim_r[0]  <= '0;
      den_r[0]  <= den2_r;
    end
  end

  // One quotient bit per stage for both parts.
  for (genvar k = 1; k <= W; k++) begin : g_div
    logic [NW-1:0] rre_nxt, rim_nxt;
    logic          qb_re, qb_im;
    logic [W-1:0]  qre_nxt, qim_nxt;

    cau_div_step #(.NW(NW), .DW(DW), .XW(XW), .SH(W - k)) u_step_re (
      .rem     (rre_r[k-1]),
      .den     (den_r[k-1]),
      .rem_nxt (rre_nxt),
      .qbit    (qb_re)
    );

    cau_div_step #(.NW(NW), .DW(DW), .XW(XW), .SH(W - k)) u_step_im (
      .rem     (rim_r[k-1]),
      .den     (den_r[k-1]),
      .rem_nxt (rim_nxt),
      .qbit    (qb_im)
    );

    always_comb begin
      qre_nxt        = qre_r[k-1];
      qim_nxt        = qim_r[k-1];
      qre_nxt[W - k] = qb_re;
      qim_nxt[W - k] = qb_im;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vd_r[k] <= 1'b0;
      end else if (en_d[k]) begin
        vd_r[k] <= vd_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en_d[k]) begin
        meta_r[k] <= meta_r[k-1];
        rre_r[k]  <= rre_nxt;
        rim_r[k]  <= rim_nxt;
        qre_r[k]  <= qre_nxt;
        qim_r[k]  <= qim_nxt;
        den_r[k]  <= den_r[k-1];
      end
    end
  end

  // Enable chain from the output register back to the input.
  always_comb begin
    en_out  = !out_ch.valid || out_ch.ready;
    en_d[W] = !vd_r[W] || en_out;
    for (int i = W - 1; i >= 0; i--) begin
      en_d[i] = !vd_r[i] || en_d[i+1];
    end
    en2 = !v2_r || en_d[0];
    en1 = !v1_r || en2;
  end

  assign in_ch.ready = en1;

  // Output stage: pass the sum or product, or sign the quotient (zero on a zero divisor), then clip to W bits.
  logic                 vo_r;
  logic signed [W-1:0]  res_re_r, res_im_r;
  logic                 sat_r, dz_r;

  meta_t                mf;
  logic signed [PW-1:0] fre, fim;
  logic [PW-1:0]        ure, uim;
  logic [W:0]           cre, cim;

  always_comb begin
    mf  = meta_r[W];
    ure = mf.ovf_re ? (PW'(1) << W) : PW'(qre_r[W]);
    uim = mf.ovf_im ? (PW'(1) << W) : PW'(qim_r[W]);
    if (!mf.div) begin
      fre = mf.val_re;
      fim = mf.val_im;
    end else if (mf.dz) begin
      fre = '0;
      fim = '0;
    end else begin
      fre = mf.neg_re ? -$signed(ure) : $signed(ure);
      fim = mf.neg_im ? -$signed(uim) : $signed(uim);
    end
    cre = sat_fn(fre);
    cim = sat_fn(fim);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (en_out) begin
      vo_r <= vd_r[W];
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      res_re_r <= cre[W-1:0];
      res_im_r <= cim[W-1:0];
      sat_r    <= cre[W] | cim[W];
      dz_r     <= mf.div & mf.dz;
    end
  end

  assign out_ch.valid       = vo_r;
  assign out_ch.res_re      = res_re_r;
  assign out_ch.res_im      = res_im_r;
  assign out_ch.saturated   = sat_r;
  assign out_ch.div_by_zero = dz_r;

endmodule

>>> sim/complex_arith_unit_test.sv
// ----------------------------------------------------------------------------
// complex_arith_unit_test
// Self-checking testbench for the complex arithmetic unit. A driver sends
// operand beats from a queue under several idling phases, and a monitor
// predicts each result at input acceptance and checks it at output acceptance.
// ----------------------------------------------------------------------------
module complex_arith_unit_test;
  import cau_pkg::*;

  localparam int DW         = 16;
  localparam int FB         = 8;
  localparam int WATCH_MAX  = 4000;
  localparam int DRAIN_WAIT = 2 * (DW + 4) + 10;

  typedef struct {
    action_t         act;
    logic signed [DW-1:0] a_re;
    logic signed [DW-1:0] a_im;
    logic signed [DW-1:0] b_re;
    logic signed [DW-1:0] b_im;
  } operands_t;

  typedef struct {
    logic signed [DW-1:0] re;
    logic signed [DW-1:0] im;
    logic                 sat;
    logic                 dz;
  } cplx_result_t;

  logic clk;
  logic rst_n;

  cau_in_if  #(.DATA_WIDTH(DW)) in_if ();
  cau_out_if #(.DATA_WIDTH(DW)) out_if ();

  complex_arith_unit #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  operands_t    pending_ops[$];
  cplx_result_t expected_results[$];
  int           send_idle_pct;
  int           recv_stall_pct;
  int           mismatches;
  int           quiet_cycles;

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Clip a wide value to the signed result range.
  function automatic logic signed [DW-1:0] clip_part(input longint v, inout logic clipped);
    longint maxv;
    longint minv;
    maxv = (longint'(1) <<< (DW - 1)) - 1;
    minv = -(longint'(1) <<< (DW - 1));
    if (v > maxv) begin
      clipped = 1'b1;
      return maxv[DW-1:0];
    end
    if (v < minv) begin
      clipped = 1'b1;
      return minv[DW-1:0];
    end
    return v[DW-1:0];
  endfunction

  // Exact complex arithmetic in 64-bit signed words, then saturation.
  function automatic cplx_result_t complex_result(input operands_t op);
    cplx_result_t r;
    longint ar, ai, br, bi, re, im, den;
    logic clipped;
    ar = op.a_re;
    ai = op.a_im;
    br = op.b_re;
    bi = op.b_im;
    re = 0;
    im = 0;
    clipped = 1'b0;
    r.dz = 1'b0;
    case (op.act)
      ACT_ADD: begin
        re = ar + br;
        im = ai + bi;
      end
      ACT_SUB: begin
        re = ar - br;
        im = ai - bi;
      end
      ACT_MUL: begin
        re = (ar * br - ai * bi) >>> FB;
        im = (ar * bi + ai * br) >>> FB;
      end
      default: begin
        den = br * br + bi * bi;
        if (den == 0) begin
          r.dz = 1'b1;
        end else begin
          // SystemVerilog signed division truncates toward zero.
          re = ((ar * br + ai * bi) <<< FB) / den;
          im = ((br * ai - ar * bi) <<< FB) / den;
        end
      end
    endcase
    r.re  = clip_part(re, clipped);
    r.im  = clip_part(im, clipped);
    r.sat = clipped;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("result %s: got %0d, expected %0d", what, got, want);
    mismatches++;
  endtask

  // Driver: presents the next queued beat once the current one is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_if.ready) begin
      if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_if.valid  <= 1'b1;
        in_if.action <= pending_ops[0].act;
        in_if.a_re   <= pending_ops[0].a_re;
        in_if.a_im   <= pending_ops[0].a_im;
        in_if.b_re   <= pending_ops[0].b_re;
        in_if.b_im   <= pending_ops[0].b_im;
        pending_ops.pop_front();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: predict on input beats, check on result beats, watch for hangs.
  always @(posedge clk) begin
    operands_t    op;
    cplx_result_t want;
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        op.act  = in_if.action;
        op.a_re = in_if.a_re;
        op.a_im = in_if.a_im;
        op.b_re = in_if.b_re;
        op.b_im = in_if.b_im;
        expected_results.push_back(complex_result(op));
      end
      if (out_if.valid && out_if.ready) begin
        if (expected_results.size() == 0) begin
          // A result beat with nothing outstanding.
          report_mismatch("beat", 1, 0);
        end else begin
          want = expected_results.pop_front();
          if (out_if.res_re !== want.re) report_mismatch("re", out_if.res_re, want.re);
          if (out_if.res_im !== want.im) report_mismatch("im", out_if.res_im, want.im);
          if (out_if.saturated !== want.sat)
            report_mismatch("saturated", out_if.saturated, want.sat);
          if (out_if.div_by_zero !== want.dz)
            report_mismatch("div_by_zero", out_if.div_by_zero, want.dz);
        end
      end
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCH_MAX) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  function automatic logic signed [DW-1:0] pick_operand();
    int mode;
    mode = $urandom_range(9);
    if (mode < 4) return DW'($urandom());
    if (mode < 8) return DW'($urandom_range(2047) - 1024);
    case ($urandom_range(4))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sh0000;
      3: return 16'sh0100;
      default: return 16'shffff;
    endcase
  endfunction

  function automatic operands_t build_op(input action_t act, input int ar, input int ai,
                                        input int br, input int bi);
    operands_t op;
    op.act  = act;
    op.a_re = ar[DW-1:0];
    op.a_im = ai[DW-1:0];
    op.b_re = br[DW-1:0];
    op.b_im = bi[DW-1:0];
    return op;
  endfunction

  // Stimulus and phase control.
  initial begin
    operands_t op;
    int phase;
    mismatches     = 0;
    quiet_cycles   = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst_n          = 1'b0;
    in_if.valid    = 1'b0;
    in_if.action   = ACT_ADD;
    in_if.a_re     = '0;
    in_if.a_im     = '0;
    in_if.b_re     = '0;
    in_if.b_im     = '0;
    out_if.ready   = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed beats: every action, extremes, saturation and zero divisor.
    pending_ops.push_back(build_op(ACT_ADD, 256, -512, 768, 1));
    pending_ops.push_back(build_op(ACT_ADD, 32767, 32767, 1, 32767));
    pending_ops.push_back(build_op(ACT_ADD, -32768, -32768, -1, -32768));
    pending_ops.push_back(build_op(ACT_SUB, 1000, -1000, 300, 200));
    pending_ops.push_back(build_op(ACT_SUB, 32767, -32768, -32768, 32767));
    pending_ops.push_back(build_op(ACT_SUB, -32768, 0, 0, -32768));
    pending_ops.push_back(build_op(ACT_MUL, 256, 256, 256, -256));
    pending_ops.push_back(build_op(ACT_MUL, -1, -1, 1, 0));
    pending_ops.push_back(build_op(ACT_MUL, 32767, 32767, 32767, 32767));
    pending_ops.push_back(build_op(ACT_MUL, -32768, -32768, -32768, -32768));
    pending_ops.push_back(build_op(ACT_MUL, -32768, 32767, 32767, -32768));
    pending_ops.push_back(build_op(ACT_DIV, 512, 256, 256, 0));
    pending_ops.push_back(build_op(ACT_DIV, 100, -37, 0, 0));
    pending_ops.push_back(build_op(ACT_DIV, 0, 0, 0, 0));
    pending_ops.push_back(build_op(ACT_DIV, -32768, -32768, 1, 0));
    pending_ops.push_back(build_op(ACT_DIV, 32767, 32767, -32768, -32768));
    pending_ops.push_back(build_op(ACT_DIV, -7, 5, 3, -2));
    pending_ops.push_back(build_op(ACT_DIV, 32767, -32768, 0, 1));
    pending_ops.push_back(build_op(ACT_DIV, 1, 1, 32767, -32768));

    // Random beats over four idling phases.
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      repeat (225) begin
        op.act  = action_t'($urandom_range(3));
        op.a_re = pick_operand();
        op.a_im = pick_operand();
        if (op.act == ACT_DIV && $urandom_range(19) == 0) begin
          op.b_re = '0;
          op.b_im = '0;
        end else begin
          op.b_re = pick_operand();
          op.b_im = pick_operand();
        end
        pending_ops.push_back(op);
      end
      while (pending_ops.size() > 0 || in_if.valid) @(posedge clk);
    end

    while (expected_results.size() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
